FILE: rtl/core/bipolar_swing_peak_detector_assert.svh
// assertion macros for the swing peak detector
`ifndef BIPOLAR_SWING_PEAK_DETECTOR_ASSERT_SVH
`define BIPOLAR_SWING_PEAK_DETECTOR_ASSERT_SVH

// same-cycle implication
`define BSPD_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSPD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bspd_pkg.sv
package bspd_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int TIME_BITS_DEF   = 32;
   localparam int LEN_BITS        = 24;

   localparam int HIGH_THR_RESET  = 2867;
   localparam int LOW_THR_RESET   = -2253;
   localparam int WINDOW_LEN_RESET  = 250000;
   localparam int HOLDOFF_LEN_RESET = 250000;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HIGH_THRESHOLD    = 2'd0,
      CSR_LOW_THRESHOLD     = 2'd1,
      CSR_WINDOW_LENGTH_US  = 2'd2,
      CSR_HOLDOFF_LENGTH_US = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic below_low;
      logic above_high;
   } class_type;

endpackage

FILE: rtl/core/bspd_if.sv
interface bspd_req_if #(
   parameter int TIME_BITS   = bspd_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS = bspd_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic        [TIME_BITS-1:0]   sample_time_us;
   logic signed [SAMPLE_BITS-1:0] sample_accel;

   modport source (output valid, output sample_time_us, output sample_accel, input ready);
   modport sink   (input valid, input sample_time_us, input sample_accel, output ready);
endinterface

interface bspd_rsp_if #(
   parameter int TIME_BITS   = bspd_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS = bspd_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic        [TIME_BITS-1:0]   peak_time_us;
   logic signed [SAMPLE_BITS-1:0] peak_accel;

   modport source (output valid, output peak_time_us, output peak_accel, input ready);
   modport sink   (input valid, input peak_time_us, input peak_accel, output ready);
endinterface

FILE: rtl/core/bspd_front.sv
module bspd_front #(
   parameter int TIME_BITS   = bspd_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS = bspd_pkg::SAMPLE_BITS_DEF,
   parameter int ENTRY_BITS  = TIME_BITS + SAMPLE_BITS + $bits(bspd_pkg::class_type)
) (
   bspd_req_if.sink                      req_chan,
   input  logic signed [SAMPLE_BITS-1:0] high_threshold,
   input  logic signed [SAMPLE_BITS-1:0] low_threshold,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic        [ENTRY_BITS-1:0]  push_data
);

   bspd_pkg::class_type cls;

   always_comb begin
      cls.below_low  = req_chan.sample_accel < low_threshold;
      cls.above_high = req_chan.sample_accel > high_threshold;
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;
   assign push_data      = {cls, req_chan.sample_time_us, req_chan.sample_accel};

endmodule

FILE: rtl/core/bspd_queue.sv
module bspd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_ready  = count_ff != CNT_BITS'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: rtl/core/bspd_back.sv
module bspd_back #(
   parameter int TIME_BITS   = bspd_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS = bspd_pkg::SAMPLE_BITS_DEF,
   parameter int ENTRY_BITS  = TIME_BITS + SAMPLE_BITS + $bits(bspd_pkg::class_type)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  logic [ENTRY_BITS-1:0]          pop_data,
   input  logic [bspd_pkg::LEN_BITS-1:0]  window_length_us,
   input  logic [bspd_pkg::LEN_BITS-1:0]  holdoff_length_us,
   bspd_rsp_if.source                     rsp_chan
);

   localparam int CLASS_BITS = $bits(bspd_pkg::class_type);
   localparam int SUM_BITS   =
      ((TIME_BITS > bspd_pkg::LEN_BITS) ? TIME_BITS : bspd_pkg::LEN_BITS) + 1;
   localparam logic [SUM_BITS-1:0] TIME_MAX = SUM_BITS'({TIME_BITS{1'b1}});

   logic                   [TIME_BITS-1:0] t;
   logic signed          [SAMPLE_BITS-1:0] a;
   bspd_pkg::class_type                    cls;

   logic                          window_open_ff, window_open_in;
   logic                          went_low_ff, went_low_in;
   logic                          went_high_ff, went_high_in;
   logic                          swing_seen_ff, swing_seen_in;
   logic        [TIME_BITS-1:0]   window_end_ff, window_end_in;
   logic signed [SAMPLE_BITS-1:0] best_value_ff, best_value_in;
   logic        [TIME_BITS-1:0]   best_time_ff, best_time_in;
   logic        [TIME_BITS-1:0]   holdoff_end_ff, holdoff_end_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic        [TIME_BITS-1:0]   peak_time_ff;
   logic signed [SAMPLE_BITS-1:0] peak_accel_ff;

   logic                advance, emit;
   logic [SUM_BITS-1:0] window_sum, holdoff_sum;
   logic [TIME_BITS-1:0] window_end_sat, holdoff_end_sat;

   assign a   = pop_data[SAMPLE_BITS-1:0];
   assign t   = pop_data[SAMPLE_BITS +: TIME_BITS];
   assign cls = bspd_pkg::class_type'(pop_data[TIME_BITS+SAMPLE_BITS +: CLASS_BITS]);

   assign advance   = pop_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pop_ready = advance;

   // saturating end times
   assign window_sum      = SUM_BITS'(t) + SUM_BITS'(window_length_us);
   assign holdoff_sum     = SUM_BITS'(best_time_ff) + SUM_BITS'(holdoff_length_us);
   assign window_end_sat  = (window_sum > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                                    : window_sum[TIME_BITS-1:0];
   assign holdoff_end_sat = (holdoff_sum > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                                     : holdoff_sum[TIME_BITS-1:0];

   always_comb begin
      window_open_in = window_open_ff;
      went_low_in    = went_low_ff;
      went_high_in   = went_high_ff;
      swing_seen_in  = swing_seen_ff;
      window_end_in  = window_end_ff;
      best_value_in  = best_value_ff;
      best_time_in   = best_time_ff;
      holdoff_end_in = holdoff_end_ff;
      emit           = 1'b0;
      if (advance && (t > holdoff_end_ff)) begin
         priority if (!window_open_ff) begin
            if (cls.below_low || cls.above_high) begin
               window_open_in = 1'b1;
               window_end_in  = window_end_sat;
               went_low_in    = cls.below_low;
               went_high_in   = !cls.below_low;
               best_value_in  = a;
               best_time_in   = t;
            end
         end else if (t < window_end_ff) begin
            if ((went_high_ff && cls.below_low) || (went_low_ff && cls.above_high)) begin
               swing_seen_in = 1'b1;
            end
            if (a > best_value_ff) begin
               best_value_in = a;
               best_time_in  = t;
            end
         end else begin
            // window close
            emit           = swing_seen_ff;
            window_open_in = 1'b0;
            went_low_in    = 1'b0;
            went_high_in   = 1'b0;
            swing_seen_in  = 1'b0;
            holdoff_end_in = holdoff_end_sat;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_open_ff <= 1'b0;
         went_low_ff    <= 1'b0;
         went_high_ff   <= 1'b0;
         swing_seen_ff  <= 1'b0;
         window_end_ff  <= '0;
         best_value_ff  <= '0;
         best_time_ff   <= '0;
         holdoff_end_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_open_ff <= window_open_in;
         went_low_ff    <= went_low_in;
         went_high_ff   <= went_high_in;
         swing_seen_ff  <= swing_seen_in;
         window_end_ff  <= window_end_in;
         best_value_ff  <= best_value_in;
         best_time_ff   <= best_time_in;
         holdoff_end_ff <= holdoff_end_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         peak_time_ff  <= best_time_ff;
         peak_accel_ff <= best_value_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.peak_time_us = peak_time_ff;
   assign rsp_chan.peak_accel   = peak_accel_ff;

endmodule

FILE: rtl/core/bipolar_swing_peak_detector.sv
// channel   dir  payload                        handshake
// req_chan  in   sample_time_us, sample_accel   valid/ready
// rsp_chan  out  peak_time_us, peak_accel       valid/ready
// csr_*     in   csr_index, csr_wdata           csr_wen, no back-pressure
//
// one request per cycle sustained while rsp_chan is not stalled; the back end updates all detector state
// once per request, behind a two-entry queue fed by the front end
// a response is valid in the cycle after the back end accepts the closing request
// reset is synchronous and returns registers to their default values, state to zero
// a stalled response holds the back end; the queue keeps req_chan ready for up to two more
`include "bipolar_swing_peak_detector_assert.svh"

module bipolar_swing_peak_detector #(
   parameter int SAMPLE_BITS = bspd_pkg::SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = bspd_pkg::TIME_BITS_DEF,
   parameter int CSR_BITS    =
      (SAMPLE_BITS > bspd_pkg::LEN_BITS) ? SAMPLE_BITS : bspd_pkg::LEN_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   bspd_req_if.sink                            req_chan,
   bspd_rsp_if.source                          rsp_chan,
   input  logic                                csr_wen,
   input  logic [bspd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]                 csr_wdata
);

   localparam int ENTRY_BITS = TIME_BITS + SAMPLE_BITS + $bits(bspd_pkg::class_type);
   localparam int LEN_BITS   = bspd_pkg::LEN_BITS;

   logic signed [SAMPLE_BITS-1:0] high_threshold_ff, low_threshold_ff;
   logic        [LEN_BITS-1:0]    window_length_ff, holdoff_length_ff;

   logic                  push_valid, push_ready;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  q_valid, q_ready;
   logic [ENTRY_BITS-1:0] q_data;
   logic                  q_pop, rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_threshold_ff <= SAMPLE_BITS'(bspd_pkg::HIGH_THR_RESET);
         low_threshold_ff  <= SAMPLE_BITS'(bspd_pkg::LOW_THR_RESET);
         window_length_ff  <= LEN_BITS'(bspd_pkg::WINDOW_LEN_RESET);
         holdoff_length_ff <= LEN_BITS'(bspd_pkg::HOLDOFF_LEN_RESET);
      end else if (csr_wen) begin
         unique case (bspd_pkg::csr_index_type'(csr_index))
            bspd_pkg::CSR_HIGH_THRESHOLD:    high_threshold_ff <= csr_wdata[SAMPLE_BITS-1:0];
            bspd_pkg::CSR_LOW_THRESHOLD:     low_threshold_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            bspd_pkg::CSR_WINDOW_LENGTH_US:  window_length_ff  <= csr_wdata[LEN_BITS-1:0];
            bspd_pkg::CSR_HOLDOFF_LENGTH_US: holdoff_length_ff <= csr_wdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   bspd_front #(
      .TIME_BITS   (TIME_BITS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_front (
      .req_chan       (req_chan),
      .high_threshold (high_threshold_ff),
      .low_threshold  (low_threshold_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   bspd_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   bspd_back #(
      .TIME_BITS   (TIME_BITS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (q_valid),
      .pop_ready         (q_ready),
      .pop_data          (q_data),
      .window_length_us  (window_length_ff),
      .holdoff_length_us (holdoff_length_ff),
      .rsp_chan          (rsp_chan)
   );

   assign q_pop     = q_valid && q_ready;
   assign rsp_stall = rsp_chan.valid && !rsp_chan.ready;

   `BSPD_ASSERT_NOW(a_full_implies_pending, clock, reset, !req_chan.ready, q_valid, "full queue")
   `BSPD_ASSERT_NOW(a_stall_holds_back, clock, reset, rsp_stall, !q_ready, "pop under stall")
   `BSPD_ASSERT_NOW(a_rsp_from_pop, clock, reset, $rose(rsp_chan.valid), $past(q_pop), "no pop")

endmodule
